>>> hdl/segment_tree_range_counter_assert.svh
// Assertion macros for the segment tree range counter.
// Included by the modules that check their own control logic; no dependencies.
`ifndef SEGMENT_TREE_RANGE_COUNTER_ASSERT_SVH
`define SEGMENT_TREE_RANGE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STC_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stc_pkg.sv
// Shared constants and types for the segment tree range counter.
// No dependencies; imported by every module of the block.
package stc_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 20;

  localparam int FIELD_BITS     = 16;
  localparam int CMD_BITS       = 2;
  localparam int OUT_COUNT_BITS = 20;
  localparam int IN_TDATA_BITS  = 48;
  localparam int OUT_TDATA_BITS = 24;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [FIELD_BITS-1:0] MAX_VALUE_RESET = 16'hFFFF;

  // Word index of a register, taken from paddr[2].
  localparam logic [0:0] REG_MAX_VALUE = 1'b0;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> hdl/stc_cfg_regs.sv
// APB register file for the segment tree range counter (max_value register).
// Depends on stc_pkg.
module stc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [stc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [stc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output logic [stc_pkg::FIELD_BITS-1:0]    max_value
);
  import stc_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
    end else if (wr_hit) begin
      max_value <= pwdata[FIELD_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_VALUE) begin
      prdata = APB_DATA_BITS'(max_value);
    end else begin
      prdata = '0;
    end
  end

endmodule

>>> hdl/stc_node_mem.sv
// Node counter store: one write port, one read port, registered read data.
// Depends on stc_pkg for the port control struct.
module stc_node_mem #(
  parameter int ADDR_BITS = 18,
  parameter int DATA_BITS = 20
) (
  input  logic                  clk,
  input  stc_pkg::mem_ctl_t     ctl,
  input  logic [ADDR_BITS-1:0]  waddr,
  input  logic [DATA_BITS-1:0]  wdata,
  input  logic [ADDR_BITS-1:0]  raddr,
  output logic [DATA_BITS-1:0]  rdata
);
  import stc_pkg::*;

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/stc_tree_walk.sv
// Tree walker: sequences clear sweeps, insert read-modify-write paths and
// range query descents over the node store, and holds the result register.
// Depends on stc_pkg and segment_tree_range_counter_assert.svh.
module stc_tree_walk #(
  parameter int VALUE_BITS = stc_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = stc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stc_pkg::CMD_BITS-1:0]        cmd,
  input  logic [stc_pkg::FIELD_BITS-1:0]      value,
  input  logic [stc_pkg::FIELD_BITS-1:0]      range_low,
  input  logic [stc_pkg::FIELD_BITS-1:0]      range_high,
  input  logic [stc_pkg::FIELD_BITS-1:0]      max_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stc_pkg::OUT_COUNT_BITS-1:0]  out_count,
  output logic                                out_error,
  output stc_pkg::mem_ctl_t                   ctl,
  output logic [VALUE_BITS+1:0]               waddr,
  output logic [COUNT_BITS-1:0]               wdata,
  output logic [VALUE_BITS+1:0]               raddr,
  input  logic [COUNT_BITS-1:0]               rdata
);
  import stc_pkg::*;
  `include "segment_tree_range_counter_assert.svh"

  localparam int IDX_BITS = VALUE_BITS + 2;
  localparam int CW       = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int SW       = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
  localparam logic [CW-1:0]         VMAX = CW'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [SW-1:0]         OMAX = SW'((64'd1 << OUT_COUNT_BITS) - 64'd1);
  localparam logic [IDX_BITS-1:0]   ROOT = IDX_BITS'(1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CLEAR   = 7'b0000010,
    ST_INS_RD  = 7'b0000100,
    ST_INS_WR  = 7'b0001000,
    ST_Q_WALK  = 7'b0010000,
    ST_Q_DRAIN = 7'b0100000,
    ST_Q_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [IDX_BITS-1:0] clr_idx, clr_idx_next;
  logic [IDX_BITS-1:0] idx, idx_next;
  logic [CW-1:0]       b, b_next, e, e_next, lo, lo_next, hi, hi_next;
  logic [CW-1:0]       key, key_next;
  logic                pend_valid, pend_valid_next;
  logic [IDX_BITS-1:0] pend_idx, pend_idx_next;
  logic [CW-1:0]       pend_b, pend_b_next, pend_e, pend_e_next, pend_hi, pend_hi_next;
  logic                pend_load;
  logic [COUNT_BITS-1:0] acc, acc_next;
  logic                acc_pending, acc_pending_next;
  logic                err, err_next;
  logic                last, last_next;
  logic [IDX_BITS-1:0] wr_idx, wr_idx_next;
  logic                out_valid_next;
  logic [OUT_COUNT_BITS-1:0] out_count_next;
  logic                out_error_next;

  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid, mid_inc;
  logic [IDX_BITS-1:0] idx_l, idx_r;
  logic [CW-1:0]       eff_max, lo_in, hi_in;
  logic                exact;
  logic [COUNT_BITS:0] acc_sum;
  logic [COUNT_BITS-1:0] acc_add, node_inc;
  logic [SW-1:0]       acc_wide;

  assign in_ready = (state == ST_IDLE);

  assign eff_max  = (CW'(max_value) > VMAX) ? VMAX : CW'(max_value);
  assign lo_in    = CW'(range_low);
  assign hi_in    = CW'(range_high);
  assign mid_sum  = {1'b0, b} + {1'b0, e};
  assign mid      = mid_sum[CW:1];
  assign mid_inc  = mid + CW'(1);
  assign idx_l    = {idx[IDX_BITS-2:0], 1'b0};
  assign idx_r    = {idx[IDX_BITS-2:0], 1'b1};
  assign exact    = (b == lo) && (e == hi);
  assign acc_sum  = {1'b0, acc} + {1'b0, rdata};
  assign acc_add  = acc_sum[COUNT_BITS] ? CMAX : acc_sum[COUNT_BITS-1:0];
  assign node_inc = (rdata == CMAX) ? rdata : rdata + COUNT_BITS'(1);
  assign acc_wide = SW'(acc);

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    idx_next        = idx;
    b_next          = b;
    e_next          = e;
    lo_next         = lo;
    hi_next         = hi;
    key_next        = key;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    pend_b_next     = pend_b;
    pend_e_next     = pend_e;
    pend_hi_next    = pend_hi;
    pend_load       = 1'b0;
    acc_next        = acc;
    err_next        = err;
    last_next       = last;
    wr_idx_next     = wr_idx;
    out_valid_next  = out_valid;
    out_count_next  = out_count;
    out_error_next  = out_error;
    ctl             = '0;
    raddr           = idx;
    waddr           = wr_idx;
    wdata           = node_inc;

    if (acc_pending) begin
      acc_next = acc_add;
    end
    if (out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_INSERT: begin
              idx_next   = ROOT;
              b_next     = '0;
              e_next     = eff_max;
              key_next   = CW'(value);
              state_next = ST_INS_RD;
            end
            CMD_QUERY: begin
              acc_next = '0;
              if (lo_in > hi_in || hi_in > eff_max) begin
                err_next   = 1'b1;
                state_next = ST_Q_DONE;
              end else begin
                err_next        = 1'b0;
                idx_next        = ROOT;
                b_next          = '0;
                e_next          = eff_max;
                lo_next         = lo_in;
                hi_next         = hi_in;
                pend_valid_next = 1'b0;
                state_next      = ST_Q_WALK;
              end
            end
            CMD_CLEAR: begin
              clr_idx_next = '0;
              state_next   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.wr_en    = 1'b1;
        waddr        = clr_idx;
        wdata        = '0;
        clr_idx_next = clr_idx + IDX_BITS'(1);
        if (&clr_idx) begin
          state_next = ST_IDLE;
        end
      end
      ST_INS_RD: begin
        ctl.rd_en   = 1'b1;
        raddr       = idx;
        wr_idx_next = idx;
        if (b < e) begin
          last_next = 1'b0;
          if (key <= mid) begin
            e_next   = mid;
            idx_next = idx_l;
          end else begin
            b_next   = mid_inc;
            idx_next = idx_r;
          end
        end else begin
          last_next = 1'b1;
        end
        state_next = ST_INS_WR;
      end
      ST_INS_WR: begin
        ctl.wr_en  = 1'b1;
        waddr      = wr_idx;
        wdata      = node_inc;
        state_next = last ? ST_IDLE : ST_INS_RD;
      end
      ST_Q_WALK: begin
        if (exact) begin
          ctl.rd_en = 1'b1;
          raddr     = idx;
          if (pend_valid) begin
            // resume the right-hand branch saved at the first split
            idx_next        = pend_idx;
            b_next          = pend_b;
            e_next          = pend_e;
            lo_next         = pend_b;
            hi_next         = pend_hi;
            pend_valid_next = 1'b0;
          end else begin
            state_next = ST_Q_DRAIN;
          end
        end else if (hi <= mid) begin
          idx_next = idx_l;
          e_next   = mid;
        end else if (lo > mid) begin
          idx_next = idx_r;
          b_next   = mid_inc;
        end else if (hi == e) begin
          // right child is covered whole: take it, keep descending left
          ctl.rd_en = 1'b1;
          raddr     = idx_r;
          idx_next  = idx_l;
          e_next    = mid;
          hi_next   = mid;
        end else if (lo == b) begin
          ctl.rd_en = 1'b1;
          raddr     = idx_l;
          idx_next  = idx_r;
          b_next    = mid_inc;
          lo_next   = mid_inc;
        end else begin
          pend_load       = 1'b1;
          pend_valid_next = 1'b1;
          pend_idx_next   = idx_r;
          pend_b_next     = mid_inc;
          pend_e_next     = e;
          pend_hi_next    = hi;
          idx_next        = idx_l;
          e_next          = mid;
          hi_next         = mid;
        end
      end
      ST_Q_DRAIN: begin
        state_next = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_error_next = err;
          out_count_next = (acc_wide > OMAX) ? OMAX[OUT_COUNT_BITS-1:0]
                                             : acc_wide[OUT_COUNT_BITS-1:0];
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    acc_pending_next = (state == ST_Q_WALK) && ctl.rd_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      pend_valid  <= 1'b0;
      acc_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      pend_valid  <= pend_valid_next;
      acc_pending <= acc_pending_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    b         <= b_next;
    e         <= e_next;
    lo        <= lo_next;
    hi        <= hi_next;
    key       <= key_next;
    pend_idx  <= pend_idx_next;
    pend_b    <= pend_b_next;
    pend_e    <= pend_e_next;
    pend_hi   <= pend_hi_next;
    acc       <= acc_next;
    err       <= err_next;
    last      <= last_next;
    wr_idx    <= wr_idx_next;
    out_count <= out_count_next;
    out_error <= out_error_next;
  end

  `STC_ASSERT_NOW(a_pend_single, clk, rst, pend_load, !pend_valid, "second pending branch")
  `STC_ASSERT_NOW(a_rw_apart, clk, rst, ctl.wr_en && ctl.rd_en, waddr != raddr, "read and write collide")
  `STC_ASSERT_NOW(a_done_drained, clk, rst, state == ST_Q_DONE, !acc_pending, "result before last sum")
  `STC_ASSERT_NEXT(a_clear_closed, clk, rst, state == ST_CLEAR && !(&clr_idx), !in_ready, "item taken during clear")

endmodule

>>> hdl/segment_tree_range_counter.sv
// Insert: one read-modify-write a node down the tree, a read state then a write state per level.
// Query: at most 2*VALUE_BITS+1 descent steps, each with at most one node read, then a drain
// state for the last sum and a done state that registers the result.
// Clear and reset: a sweep over all 2**(VALUE_BITS+2) node store entries, one entry a cycle;
// no item is taken meanwhile, configuration writes are. A result stuck behind an unread one blocks input.
// Reset: synchronous, active high; max_value returns to 65535 and the store is swept to zero.
module segment_tree_range_counter #(
  parameter int VALUE_BITS = stc_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = stc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // value [15:0], range_low [31:16], range_high [47:32]
  input  logic [stc_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  // cmd [1:0]
  input  logic [stc_pkg::CMD_BITS-1:0]        s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // count [19:0], zero [23:20]
  output logic [stc_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  // range_error [0]
  output logic [0:0]                          m_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [stc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [stc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import stc_pkg::*;

  localparam int IDX_BITS = VALUE_BITS + 2;

  logic [FIELD_BITS-1:0]     max_value;
  logic [OUT_COUNT_BITS-1:0] count;
  logic                      range_error;
  mem_ctl_t                  ctl;
  logic [IDX_BITS-1:0]       waddr, raddr;
  logic [COUNT_BITS-1:0]     wdata, rdata;

  stc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_value (max_value)
  );

  stc_tree_walk #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cmd        (s_tuser),
    .value      (s_tdata[FIELD_BITS-1:0]),
    .range_low  (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .range_high (s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
    .max_value  (max_value),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_count  (count),
    .out_error  (range_error),
    .ctl        (ctl),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  stc_node_mem #(
    .ADDR_BITS (IDX_BITS),
    .DATA_BITS (COUNT_BITS)
  ) u_mem (
    .clk   (clk),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign m_tdata = {{(OUT_TDATA_BITS-OUT_COUNT_BITS){1'b0}}, count};
  assign m_tuser = range_error;

endmodule

>>> verif/tb_segment_tree_range_counter.sv
// Self-checking testbench for segment_tree_range_counter: stream commands in, query counts out.
// Keeps its own heap-indexed counter tree and compares every returned count and error flag.
// Depends on stc_pkg and the block's RTL only.
module tb_segment_tree_range_counter;
  import stc_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;
  localparam int unsigned NODES = 1 << (VB + 2);
  localparam int unsigned VALUE_TOP = (1 << VB) - 1;
  localparam logic [CB-1:0] NODE_CAP = '1;
  localparam longint unsigned OUT_CAP = (64'd1 << OUT_COUNT_BITS) - 1;
  // insert walks one read-modify-write per level; let it finish before a register write
  localparam int SETTLE = 4 * (VB + 1);
  // a clear sweep is the longest stretch with no transfer
  localparam int IDLE_LIMIT = 4 * NODES;
  localparam int PHASE_OPS = 190;
  localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [CMD_BITS-1:0]   cmd;
    logic [FIELD_BITS-1:0] value;
    logic [FIELD_BITS-1:0] lo;
    logic [FIELD_BITS-1:0] hi;
  } tree_op_t;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] count;
    logic                      range_error;
  } tally_t;

  typedef struct {
    int unsigned idx;
    int unsigned b;
    int unsigned e;
    int unsigned l;
    int unsigned h;
  } span_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_BITS-1:0] s_tdata = '0;
  logic [CMD_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  logic [CB-1:0] node_cnt [0:NODES-1];
  logic [FIELD_BITS-1:0] max_value_cfg = MAX_VALUE_RESET;
  tree_op_t op_queue[$];
  tally_t pending_counts[$];
  logic took_item = 1'b0;
  logic quiet = 1'b0;
  int queued_n = 0;
  int taken_n = 0;
  int idle_cycles = 0;
  int fails = 0;
  int cfg_fails = 0;
  int n_ins = 0, n_qry = 0, n_err = 0, n_clr = 0, n_none = 0, n_cfg = 0;

  segment_tree_range_counter #(
    .VALUE_BITS(VB),
    .COUNT_BITS(CB)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (node_cnt[i]) node_cnt[i] = '0;
  end

  function automatic int unsigned root_top();
    return (max_value_cfg > VALUE_TOP) ? VALUE_TOP : max_value_cfg;
  endfunction

  function automatic void bump_node(int unsigned idx);
    int unsigned k;
    k = idx & (NODES - 1);
    if (node_cnt[k] != NODE_CAP) node_cnt[k] = node_cnt[k] + 1'b1;
  endfunction

  // Walk root to leaf; values past the root range keep taking the right child.
  function automatic void insert_value(int unsigned v);
    int unsigned b, e, idx, m;
    b = 0;
    e = root_top();
    idx = 1;
    while (b < e) begin
      m = (b + e) / 2;
      bump_node(idx);
      if (v <= m) begin
        e = m;
        idx = idx * 2;
      end else begin
        b = m + 1;
        idx = idx * 2 + 1;
      end
    end
    bump_node(idx);
  endfunction

  // Sum the nodes that cover lo..hi exactly. All terms are non-negative, so capping
  // the grand total equals capping at every split.
  function automatic tally_t range_count(int unsigned lo, int unsigned hi);
    span_t stack [64];
    span_t cur;
    int sp;
    int unsigned m;
    longint unsigned total;
    tally_t r;
    r = '0;
    if (lo > hi || hi > root_top()) begin
      r.range_error = 1'b1;
      return r;
    end
    total = 0;
    stack[0] = '{idx: 1, b: 0, e: root_top(), l: lo, h: hi};
    sp = 1;
    while (sp > 0) begin
      sp = sp - 1;
      cur = stack[sp];
      if (cur.b == cur.l && cur.e == cur.h) begin
        total = total + node_cnt[cur.idx & (NODES - 1)];
      end else begin
        m = (cur.b + cur.e) / 2;
        if (cur.h <= m) begin
          stack[sp] = '{idx: cur.idx * 2, b: cur.b, e: m, l: cur.l, h: cur.h};
          sp = sp + 1;
        end else if (cur.l > m) begin
          stack[sp] = '{idx: cur.idx * 2 + 1, b: m + 1, e: cur.e, l: cur.l, h: cur.h};
          sp = sp + 1;
        end else begin
          stack[sp] = '{idx: cur.idx * 2, b: cur.b, e: m, l: cur.l, h: m};
          stack[sp + 1] = '{idx: cur.idx * 2 + 1, b: m + 1, e: cur.e, l: m + 1, h: cur.h};
          sp = sp + 2;
        end
      end
    end
    if (total > NODE_CAP) total = NODE_CAP;
    if (total > OUT_CAP) total = OUT_CAP;
    r.count = total[OUT_COUNT_BITS-1:0];
    return r;
  endfunction

  // Input driver: present the next command after a transfer, with random gaps unless quiet is set.
  always @(negedge clk) begin : drive_cmds
    logic nv;
    tree_op_t op;
    nv = s_tvalid;
    if (took_item) nv = 1'b0;
    if (!rst && !nv && op_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
      op = op_queue.pop_front();
      s_tdata <= {op.hi, op.lo, op.value};
      s_tuser <= op.cmd;
      nv = 1'b1;
    end
    s_tvalid <= nv;
  end

  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= 24);
  end

  // Monitor, tree update and watchdog, all on the sampling edge.
  always @(posedge clk) begin : watch_ports
    tally_t want;
    logic [FIELD_BITS-1:0] v, lo, hi;
    took_item <= s_tvalid && s_tready;

    if (m_tvalid && m_tready) begin
      if (pending_counts.size() == 0) begin
        $error("result with no query waiting: count %0d range_error %0d",
               m_tdata[OUT_COUNT_BITS-1:0], m_tuser[0]);
        fails = fails + 1;
      end else begin
        want = pending_counts.pop_front();
        if (m_tdata[OUT_COUNT_BITS-1:0] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_tdata[OUT_COUNT_BITS-1:0]);
          fails = fails + 1;
        end
        if (m_tuser[0] !== want.range_error) begin
          $error("range_error: expected %0d, got %0d", want.range_error, m_tuser[0]);
          fails = fails + 1;
        end
      end
    end

    if (s_tvalid && s_tready) begin
      taken_n <= taken_n + 1;
      v = s_tdata[FIELD_BITS-1:0];
      lo = s_tdata[2*FIELD_BITS-1:FIELD_BITS];
      hi = s_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
      case (s_tuser)
        CMD_INSERT: begin
          insert_value(v);
          n_ins = n_ins + 1;
        end
        CMD_QUERY: begin
          want = range_count(lo, hi);
          pending_counts.push_back(want);
          n_qry = n_qry + 1;
          if (want.range_error) n_err = n_err + 1;
        end
        CMD_CLEAR: begin
          foreach (node_cnt[i]) node_cnt[i] = '0;
          n_clr = n_clr + 1;
        end
        default: n_none = n_none + 1;
      endcase
    end

    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_op(logic [CMD_BITS-1:0] cmd, logic [FIELD_BITS-1:0] value,
                        logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi);
    op_queue.push_back('{cmd: cmd, value: value, lo: lo, hi: hi});
    queued_n = queued_n + 1;
  endtask

  // Hold until every command is taken and every count is back, then let an insert finish.
  task automatic drain();
    while (taken_n != queued_n || pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_BITS-1:0] wdata,
                            output logic [APB_DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_MAX_VALUE, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_max_value(logic [FIELD_BITS-1:0] v);
    logic [APB_DATA_BITS-1:0] rd;
    apb_access(1'b1, {{(APB_DATA_BITS-FIELD_BITS){1'b0}}, v}, rd);
    max_value_cfg = v;
    n_cfg = n_cfg + 1;
    apb_access(1'b0, '0, rd);
    if (rd[FIELD_BITS-1:0] !== v) begin
      $error("max_value: expected %0d, got %0d", v, rd[FIELD_BITS-1:0]);
      cfg_fails = cfg_fails + 1;
    end
  endtask

  initial begin : run_phases
    logic [FIELD_BITS-1:0] max_plan [8];
    int unsigned top, r, clear_at;
    logic [FIELD_BITS-1:0] v, lo, hi;
    max_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h00FF, 16'hFFFE,
                 16'($urandom_range(2, 64)), 16'($urandom()), 16'hFFFF};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // full range: both ends, the midpoint split, a bad range, the unused code, clear
    set_max_value(16'hFFFF);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'hFFFF);
    add_op(CMD_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_op(CMD_INSERT, 16'hFFFF, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd32767, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd32768, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd12345, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd12345, 16'h0000, 16'h0000);
    add_op(CMD_QUERY, 16'hFFFF, 16'h0000, 16'h0000);
    add_op(CMD_QUERY, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_op(CMD_QUERY, 16'h0000, 16'd32767, 16'd32768);
    add_op(CMD_QUERY, 16'h0000, 16'd100, 16'd40000);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'hFFFF);
    add_op(CMD_QUERY, 16'h0000, 16'd5, 16'd4);
    add_op(CMD_NONE, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    add_op(CMD_QUERY, 16'h0000, 16'd12345, 16'd12345);
    add_op(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'hFFFF);
    drain();

    // value above the root range lands in the last leaf; upper bound past max_value
    set_max_value(16'd1000);
    add_op(CMD_INSERT, 16'd5000, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd1000, 16'h0000, 16'h0000);
    add_op(CMD_QUERY, 16'h0000, 16'd1000, 16'd1000);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'd1001);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'd1000);
    drain();

    // single-leaf tree
    set_max_value(16'h0000);
    add_op(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000);
    add_op(CMD_INSERT, 16'd9, 16'h0000, 16'h0000);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'h0000);
    add_op(CMD_QUERY, 16'h0000, 16'h0000, 16'h0001);
    drain();

    // random phases; the store is kept across settings so stale nodes get read too
    for (int ph = 0; ph < 8; ph++) begin
      set_max_value(max_plan[ph]);
      quiet = (ph == 4);
      top = root_top();
      clear_at = (ph == 6) ? $urandom_range(20, PHASE_OPS - 20) : PHASE_OPS;
      for (int k = 0; k < PHASE_OPS; k++) begin
        v = 16'($urandom());
        lo = 16'($urandom());
        hi = 16'($urandom());
        r = $urandom_range(0, 99);
        if (k == clear_at) begin
          add_op(CMD_CLEAR, v, lo, hi);
        end else if (r < 4) begin
          add_op(CMD_NONE, v, lo, hi);
        end else if (r < 52) begin
          if ($urandom_range(0, 99) < 80) v = 16'($urandom_range(0, top));
          add_op(CMD_INSERT, v, lo, hi);
        end else begin
          if ($urandom_range(0, 99) < 80) begin
            lo = 16'($urandom_range(0, top));
            hi = 16'($urandom_range(lo, top));
          end
          add_op(CMD_QUERY, v, lo, hi);
        end
      end
      drain();
    end
    quiet = 1'b0;

    if (pending_counts.size() != 0)
      $error("%0d query results never arrived", pending_counts.size());
    $display("covered %0d inserts, %0d queries (%0d bad ranges), %0d clears, %0d unused codes",
             n_ins, n_qry, n_err, n_clr, n_none);
    $display("across %0d max_value settings, from a single leaf to the full range", n_cfg);
    if (fails == 0 && cfg_fails == 0 && pending_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> segment_tree_range_counter.f
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_cfg_regs.sv
hdl/stc_node_mem.sv
hdl/stc_tree_walk.sv
hdl/segment_tree_range_counter.sv
verif/tb_segment_tree_range_counter.sv
